FILE: rtl/cic_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cloud-in-cell deposit package
// Field widths, fixed-point constants and the decoded item that travels
// from the front end through the queue to the grid update engine.
// ----------------------------------------------------------------------------
package cic_pkg;

  // Channel field widths
  localparam int POS_W       = 32;
  localparam int MASS_IN_W   = 24;
  localparam int CELL_SEL_W  = 15;
  localparam int CELL_MASS_W = 48;

  // Internal widths: cell index per axis covers the largest grid side (256)
  localparam int IDX_W = 8;
  localparam int WGT_W = 17;
  localparam int ADD_W = 41;

  // Weight of one in 16 fractional bits, half a cell in 32 fractional bits
  localparam logic [WGT_W-1:0]       WGT_ONE   = 17'h1_0000;
  localparam logic [POS_W-1:0]       FRAC_HALF = 32'h8000_0000;
  localparam logic [CELL_MASS_W-1:0] MASS_MAX  = 48'hFFFF_FFFF_FFFF;

  // Commands
  localparam logic CMD_DEPOSIT = 1'b0;
  localparam logic CMD_READ    = 1'b1;

  // Queue between front end and update engine
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

  // Decoded request: a read, or a deposit split per axis
  typedef struct packed {
    logic                   is_read;
    logic                   out_of_range;
    logic [CELL_SEL_W-1:0]  read_cell;
    logic [IDX_W-1:0]       home_x;
    logic [IDX_W-1:0]       other_x;
    logic [IDX_W-1:0]       home_y;
    logic [IDX_W-1:0]       other_y;
    logic [IDX_W-1:0]       home_z;
    logic [IDX_W-1:0]       other_z;
    logic [WGT_W-1:0]       w_x;
    logic [WGT_W-1:0]       w_y;
    logic [WGT_W-1:0]       w_z;
    logic [MASS_IN_W-1:0]   mass;
  } cic_item_t;

endpackage
`default_nettype wire

FILE: rtl/cic_ifs.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cloud-in-cell channel interfaces
// Valid/ready request channel carrying deposit and read requests, and the
// result channel carrying one grid cell.
// ----------------------------------------------------------------------------
interface cic_in_if import cic_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic                  command;
  logic [POS_W-1:0]      pos_x;
  logic [POS_W-1:0]      pos_y;
  logic [POS_W-1:0]      pos_z;
  logic [MASS_IN_W-1:0]  particle_mass;
  logic [CELL_SEL_W-1:0] read_cell;

  modport source (output valid, command, pos_x, pos_y, pos_z, particle_mass, read_cell,
                  input ready);
  modport sink   (input valid, command, pos_x, pos_y, pos_z, particle_mass, read_cell,
                  output ready);
endinterface

interface cic_out_if import cic_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CELL_MASS_W-1:0] cell_mass;
  logic                   cell_saturated;

  modport source (output valid, cell_mass, cell_saturated, input ready);
  modport sink   (input valid, cell_mass, cell_saturated, output ready);
endinterface
`default_nettype wire

FILE: rtl/cic_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port; read data is registered (old data on a
// same-address read and write).
// ----------------------------------------------------------------------------
module cic_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

FILE: rtl/cic_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cloud-in-cell request queue
// Short FIFO of decoded requests between the front end and the update engine.
// ----------------------------------------------------------------------------
module cic_queue import cic_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire cic_item_t push_item,
  output logic           full,
  input  wire logic      pop,
  output logic           head_valid,
  output cic_item_t      head_item
);

  localparam int CNT_W = QPTR_W + 1;

  cic_item_t          entries_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_r, wr_ptr_nxt;
  logic [QPTR_W-1:0]  rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;

  assign full       = (count_r == CNT_W'(QUEUE_DEPTH));
  assign head_valid = (count_r != '0);
  assign head_item  = entries_r[rd_ptr_r];

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_nxt = push ? QPTR_W'(wr_ptr_r + 1'b1) : wr_ptr_r;
    rd_ptr_nxt = pop  ? QPTR_W'(rd_ptr_r + 1'b1) : rd_ptr_r;
    count_nxt  = count_r;
    if (push && !pop) begin
      count_nxt = CNT_W'(count_r + 1'b1);
    end else if (pop && !push) begin
      count_nxt = CNT_W'(count_r - 1'b1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Store payload
  always_ff @(posedge clk) begin
    if (push) begin
      entries_r[wr_ptr_r] <= push_item;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/cic_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cloud-in-cell front end
// Takes requests, splits each deposit position into home cell, neighbour
// cell and home weight per axis, checks read range, and pushes the decoded
// request into the queue.
// ----------------------------------------------------------------------------
module cic_front import cic_pkg::*; #(
  parameter int GRID_SIDE = 32
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  clearing,
  cic_in_if.sink     in_ch,
  output logic       push,
  output cic_item_t  push_item,
  input  wire logic  q_full
);

  localparam int               CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam logic [IDX_W-1:0] G_LAST     = IDX_W'(GRID_SIDE - 1);

  typedef struct packed {
    logic [IDX_W-1:0] home;
    logic [IDX_W-1:0] other;
    logic [WGT_W-1:0] w;
  } axis_t;

  logic                  stg_v_r, stg_v_nxt;
  logic                  stg_cmd_r;
  logic [POS_W-1:0]      stg_x_r, stg_y_r, stg_z_r;
  logic [MASS_IN_W-1:0]  stg_mass_r;
  logic [CELL_SEL_W-1:0] stg_cell_r;
  logic                  accept;
  axis_t                 ax_x, ax_y, ax_z;

  // Split one axis: cell from the integer part, weight from the fraction
  function automatic axis_t split_axis(input logic [POS_W-1:0] pos);
    logic [40:0]      t;
    logic [IDX_W-1:0] cell_idx;
    logic [31:0]      f;
    logic [32:0]      w32;
    axis_t            s;
    t        = 41'(pos) * 41'(GRID_SIDE);
    cell_idx = t[39:32];
    f        = t[31:0];
    if (f > FRAC_HALF) begin
      w32     = 33'h1_8000_0000 - 33'(f);
      s.other = (cell_idx == G_LAST) ? '0 : IDX_W'(cell_idx + 1'b1);
    end else begin
      w32     = 33'h0_8000_0000 + 33'(f);
      s.other = (cell_idx == '0) ? G_LAST : IDX_W'(cell_idx - 1'b1);
    end
    s.home = cell_idx;
    s.w    = w32[32:16];
    return s;
  endfunction

  // Accept while not clearing and the stage is free or draining
  assign in_ch.ready = !clearing && (!stg_v_r || !q_full);
  assign accept      = in_ch.valid && in_ch.ready;
  assign push        = stg_v_r && !q_full;

  always_comb begin
    stg_v_nxt = stg_v_r;
    if (accept) begin
      stg_v_nxt = 1'b1;
    end else if (push) begin
      stg_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else begin
      stg_v_r <= stg_v_nxt;
    end
  end

  // Hold request fields
  always_ff @(posedge clk) begin
    if (accept) begin
      stg_cmd_r  <= in_ch.command;
      stg_x_r    <= in_ch.pos_x;
      stg_y_r    <= in_ch.pos_y;
      stg_z_r    <= in_ch.pos_z;
      stg_mass_r <= in_ch.particle_mass;
      stg_cell_r <= in_ch.read_cell;
    end
  end

  // Decode the held request
  always_comb begin
    ax_x = split_axis(stg_x_r);
    ax_y = split_axis(stg_y_r);
    ax_z = split_axis(stg_z_r);
    push_item.is_read      = (stg_cmd_r == CMD_READ);
    push_item.out_of_range = ({17'd0, stg_cell_r} >= 32'(CELL_COUNT));
    push_item.read_cell    = stg_cell_r;
    push_item.home_x       = ax_x.home;
    push_item.other_x      = ax_x.other;
    push_item.home_y       = ax_y.home;
    push_item.other_y      = ax_y.other;
    push_item.home_z       = ax_z.home;
    push_item.other_z      = ax_z.other;
    push_item.w_x          = ax_x.w;
    push_item.w_y          = ax_y.w;
    push_item.w_z          = ax_z.w;
    push_item.mass         = stg_mass_r;
  end

endmodule
`default_nettype wire

FILE: rtl/cic_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cloud-in-cell update engine
// Clears the grid after reset, then walks the eight corners of each deposit
// through a weight pipeline into a read-modify-write of the grid memory, one
// cell per cycle, and serves reads through the same pipeline.
// ----------------------------------------------------------------------------
module cic_back import cic_pkg::*; #(
  parameter int GRID_SIDE = 32
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      head_valid,
  input  wire cic_item_t head_item,
  output logic           pop,
  output logic           clearing,
  cic_out_if.source      out_ch
);

  localparam int CELL_COUNT = GRID_SIDE * GRID_SIDE * GRID_SIDE;
  localparam int AW         = $clog2(CELL_COUNT);
  localparam int RAM_W      = CELL_MASS_W + 1;
  localparam logic [AW-1:0] G_A       = AW'(GRID_SIDE);
  localparam logic [AW-1:0] CLR_LAST  = AW'(CELL_COUNT - 1);

  typedef enum logic [2:0] {
    ST_CLEAR   = 3'b001,
    ST_IDLE    = 3'b010,
    ST_DEPOSIT = 3'b100
  } back_state_t;

  back_state_t state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;
  cic_item_t     cur_r, cur_nxt;
  logic [2:0]    k_r, k_nxt;

  // Issue stage
  logic                 iss_v, iss_rd, iss_oor;
  logic [AW-1:0]        iss_addr;
  logic [33:0]          iss_p1;
  logic [WGT_W-1:0]     iss_c;
  logic [2:0]           sel;
  logic [IDX_W-1:0]     cx, cy, cz;
  logic [WGT_W-1:0]     wa, wb, wc;
  logic                 read_busy, take_dep, take_rd;

  // Pipeline stages
  logic                 s1_v_r, s1_rd_r, s1_oor_r;
  logic [AW-1:0]        s1_addr_r;
  logic [33:0]          s1_p1_r;
  logic [WGT_W-1:0]     s1_c_r;
  logic [MASS_IN_W-1:0] s1_mass_r;
  logic [50:0]          p2;

  logic                 s2_v_r, s2_rd_r, s2_oor_r;
  logic [AW-1:0]        s2_addr_r;
  logic [32:0]          s2_w_r;
  logic [MASS_IN_W-1:0] s2_mass_r;
  logic [56:0]          prod;
  logic                 fwd_hit;

  logic                 s3_v_r, s3_rd_r, s3_oor_r, s3_fwd_r;
  logic [AW-1:0]        s3_addr_r;
  logic [ADD_W-1:0]     s3_add_r;
  logic [RAM_W-1:0]     last_wr_r;

  // Memory and update
  logic [RAM_W-1:0]     rdata, old_cell, new_cell;
  logic [CELL_MASS_W:0] sum;
  logic                 s3_wr;
  logic                 ram_we;
  logic [AW-1:0]        ram_waddr;
  logic [RAM_W-1:0]     ram_wdata;

  // Result register
  logic                   out_v_r, out_v_nxt;
  logic [CELL_MASS_W-1:0] out_mass_r;
  logic                   out_sat_r;

  // Corner order: home, x, y, z, xy, yz, xz, xyz (bit 0 x, bit 1 y, bit 2 z)
  function automatic logic [2:0] corner_sel(input logic [2:0] k);
    logic [2:0] c;
    unique case (k)
      3'd0:    c = 3'b000;
      3'd1:    c = 3'b001;
      3'd2:    c = 3'b010;
      3'd3:    c = 3'b100;
      3'd4:    c = 3'b011;
      3'd5:    c = 3'b110;
      3'd6:    c = 3'b101;
      3'd7:    c = 3'b111;
      default: c = 3'b000;
    endcase
    return c;
  endfunction

  assign clearing  = (state_r == ST_CLEAR);
  assign read_busy = out_v_r || (s1_v_r && s1_rd_r) || (s2_v_r && s2_rd_r)
                     || (s3_v_r && s3_rd_r);
  assign take_dep  = head_valid && !head_item.is_read;
  assign take_rd   = head_valid && head_item.is_read && !read_busy;

  // Corner selection for the current deposit
  always_comb begin
    sel = corner_sel(k_r);
    cx  = sel[0] ? cur_r.other_x : cur_r.home_x;
    cy  = sel[1] ? cur_r.other_y : cur_r.home_y;
    cz  = sel[2] ? cur_r.other_z : cur_r.home_z;
    wa  = sel[0] ? WGT_W'(WGT_ONE - cur_r.w_x) : cur_r.w_x;
    wb  = sel[1] ? WGT_W'(WGT_ONE - cur_r.w_y) : cur_r.w_y;
    wc  = sel[2] ? WGT_W'(WGT_ONE - cur_r.w_z) : cur_r.w_z;
  end

  // Sequence: clear sweep, then one corner per cycle, or one read once no earlier read is pending
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    cur_nxt      = cur_r;
    k_nxt        = k_r;
    pop          = 1'b0;
    iss_v        = 1'b0;
    iss_rd       = 1'b0;
    iss_oor      = 1'b0;
    iss_addr     = '0;
    iss_p1       = '0;
    iss_c        = '0;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = AW'(clr_addr_r + 1'b1);
        if (clr_addr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (take_dep) begin
          pop       = 1'b1;
          cur_nxt   = head_item;
          k_nxt     = '0;
          state_nxt = ST_DEPOSIT;
        end else if (take_rd) begin
          pop      = 1'b1;
          iss_v    = 1'b1;
          iss_rd   = 1'b1;
          iss_oor  = head_item.out_of_range;
          iss_addr = AW'(head_item.read_cell);
        end
      end
      ST_DEPOSIT: begin
        iss_v    = 1'b1;
        iss_addr = AW'((AW'(cx) * G_A + AW'(cy)) * G_A + AW'(cz));
        iss_p1   = 34'(wa) * 34'(wb);
        iss_c    = wc;
        k_nxt    = 3'(k_r + 1'b1);
        if (k_r == 3'd7) begin
          if (take_dep) begin
            pop     = 1'b1;
            cur_nxt = head_item;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
      k_r        <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
      k_r        <= k_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r <= cur_nxt;
  end

  // Stage 2 weight product and stage 3 mass product
  assign p2   = 51'(s1_p1_r) * 51'(s1_c_r);
  assign prod = 57'(s2_w_r) * 57'(s2_mass_r);

  // Forward the cell written this cycle to a read of the same cell
  assign fwd_hit = s3_v_r && !s3_rd_r && (s3_addr_r == s2_addr_r);

  // Pipeline valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else begin
      s1_v_r <= iss_v;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  // Pipeline payload
  always_ff @(posedge clk) begin
    s1_rd_r   <= iss_rd;
    s1_oor_r  <= iss_oor;
    s1_addr_r <= iss_addr;
    s1_p1_r   <= iss_p1;
    s1_c_r    <= iss_c;
    s1_mass_r <= cur_r.mass;
    s2_rd_r   <= s1_rd_r;
    s2_oor_r  <= s1_oor_r;
    s2_addr_r <= s1_addr_r;
    s2_w_r    <= p2[48:16];
    s2_mass_r <= s1_mass_r;
    s3_rd_r   <= s2_rd_r;
    s3_oor_r  <= s2_oor_r;
    s3_addr_r <= s2_addr_r;
    s3_add_r  <= prod[56:16];
    s3_fwd_r  <= fwd_hit;
    if (s3_wr) begin
      last_wr_r <= new_cell;
    end
  end

  // Add and saturate
  always_comb begin
    old_cell = s3_fwd_r ? last_wr_r : rdata;
    sum      = {1'b0, old_cell[CELL_MASS_W-1:0]} + (CELL_MASS_W + 1)'(s3_add_r);
    if (sum >= {1'b0, MASS_MAX}) begin
      new_cell = {1'b1, MASS_MAX};
    end else begin
      new_cell = {old_cell[CELL_MASS_W], sum[CELL_MASS_W-1:0]};
    end
  end

  assign s3_wr     = s3_v_r && !s3_rd_r;
  assign ram_we    = clearing || s3_wr;
  assign ram_waddr = clearing ? clr_addr_r : s3_addr_r;
  assign ram_wdata = clearing ? '0 : new_cell;

  cic_ram #(
    .WIDTH (RAM_W),
    .DEPTH (CELL_COUNT)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (s2_v_r),
    .raddr (s2_addr_r),
    .rdata (rdata)
  );

  // Result register: load on a read, drop on handoff
  always_comb begin
    out_v_nxt = out_v_r;
    if (s3_v_r && s3_rd_r) begin
      out_v_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_v_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else begin
      out_v_r <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_v_r && s3_rd_r) begin
      out_mass_r <= s3_oor_r ? '0 : old_cell[CELL_MASS_W-1:0];
      out_sat_r  <= s3_oor_r ? 1'b0 : old_cell[CELL_MASS_W];
    end
  end

  assign out_ch.valid          = out_v_r;
  assign out_ch.cell_mass      = out_mass_r;
  assign out_ch.cell_saturated = out_sat_r;

endmodule
`default_nettype wire

FILE: rtl/cloud_in_cell_mass_deposit.sv
`timescale 1ns / 1ps
`default_nettype none
// A deposit walks its corners in the grid engine, one cell read-modify-write per cycle on
// the grid memory, after a load when the engine was idle; a queued deposit is loaded as
// the last corner of the one before issues (2-deep queue plus one front stage ahead).
// A read issues from the idle engine and passes the pipeline stages into the result
// register; the next read waits until that result is taken.
// Reset starts a clearing pass of GRID_SIDE^3 cells (32768 at the default), no requests.
// ----------------------------------------------------------------------------
// Cloud-in-cell mass deposit
// Periodic cubic mass grid with cloud-in-cell particle deposit and cell read.
// ----------------------------------------------------------------------------
module cloud_in_cell_mass_deposit import cic_pkg::*; #(
  parameter int GRID_SIDE = 32
) (
  input  wire logic clk,
  input  wire logic rst_n,
  cic_in_if.sink    in_ch,
  cic_out_if.source out_ch
);

  logic      clearing;
  logic      q_push;
  cic_item_t q_push_item;
  logic      q_full;
  logic      q_pop;
  logic      q_head_valid;
  cic_item_t q_head_item;

  cic_front #(
    .GRID_SIDE (GRID_SIDE)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .clearing  (clearing),
    .in_ch     (in_ch),
    .push      (q_push),
    .push_item (q_push_item),
    .q_full    (q_full)
  );

  cic_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (q_push),
    .push_item  (q_push_item),
    .full       (q_full),
    .pop        (q_pop),
    .head_valid (q_head_valid),
    .head_item  (q_head_item)
  );

  cic_back #(
    .GRID_SIDE (GRID_SIDE)
  ) u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (q_head_valid),
    .head_item  (q_head_item),
    .pop        (q_pop),
    .clearing   (clearing),
    .out_ch     (out_ch)
  );

`ifndef NO_ASSERTIONS
  // No request is taken while the grid is being cleared
  a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    clearing |-> !in_ch.ready)
    else $error("request accepted during grid clear");

  // Queue never overflows or underflows
  a_queue_push: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("push into full queue");

  a_queue_pop: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> (q_head_valid && !clearing))
    else $error("pop from empty queue or during clear");

  // Reset always restarts the clearing pass
  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> clearing)
    else $error("clearing pass not started by reset");
`endif

endmodule
`default_nettype wire
